// ===== sv/wlp_pkg.sv =====
package wlp_pkg;

    localparam int COORD_WIDTH = 20;
    localparam int FRAC_BITS   = 4;
    localparam int CFG_W       = 12;

    // Absolute coordinate differences fit in COORD_WIDTH unsigned bits.
    localparam int DIFF_W = COORD_WIDTH;
    localparam int PROD_W = 2 * DIFF_W;
    // Segment length in sub-pixel units, and the square-root datapath.
    localparam int SQ_W   = DIFF_W + 1;
    localparam int RAD_W  = 2 * SQ_W;
    localparam int REM_W  = SQ_W + 3;
    localparam int SKIP_W = (SQ_W - FRAC_BITS + 2 > CFG_W + 1) ?
                            (SQ_W - FRAC_BITS + 2) : (CFG_W + 1);
    localparam int SUB_W  = SKIP_W + FRAC_BITS + 1;
    localparam int CMP_W  = SQ_W + CFG_W + FRAC_BITS;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [1:0] REG_LABEL_WIDTH    = 2'd0;
    localparam logic [1:0] REG_LABEL_SPACING  = 2'd1;
    localparam logic [1:0] REG_OUTLINE_ENABLE = 2'd2;

    localparam logic [CFG_W-1:0] RST_LABEL_WIDTH   = 12'd10;
    localparam logic [CFG_W-1:0] RST_LABEL_SPACING = 12'd500;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] vertex_x;
        logic signed [COORD_WIDTH-1:0] vertex_y;
        logic                          way_start;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] left_x;
        logic signed [COORD_WIDTH-1:0] left_y;
        logic signed [COORD_WIDTH-1:0] right_x;
        logic signed [COORD_WIDTH-1:0] right_y;
        logic                          with_outline;
    } t_out_item;

    typedef struct packed {
        logic [CFG_W-1:0] label_width;
        logic [CFG_W-1:0] label_spacing;
        logic             outline_enable;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic sq_x;
        logic sq_y;
        logic sum;
        logic root_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic new_way;
        logic emit;
    } t_sts;

endpackage

// ===== sv/way_label_placement_core.sv =====
// A vertex that closes a segment steps through the states SQX, SQY, SUM, the bit-serial
// square root (ROOT) and DONE; its result, if any, is then registered at the output.
// No new vertex is accepted until the control returns to IDLE; a vertex that starts a
// way is taken in IDLE alone. A finished item may wait in the output register while
// the next one is accepted; a label stalls in DONE while it is full.
// Reset (synchronous, active low) clears the vertex history and skip, and restores defaults.
module way_label_placement_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  wlp_pkg::t_in_item           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output wlp_pkg::t_out_item          o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wlp_pkg::APB_AW-1:0]  paddr,
    input  logic [wlp_pkg::APB_DW-1:0]  pwdata,
    output logic [wlp_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import wlp_pkg::*;

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    assign pready = 1'b1;

    wlp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    wlp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    wlp_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in_data),
        .i_cfg   (cfg),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_out   (o_out_data)
    );

endmodule

// ===== sv/wlp_regs.sv =====
module wlp_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wlp_pkg::APB_AW-1:0]  paddr,
    input  logic [wlp_pkg::APB_DW-1:0]  pwdata,
    output logic [wlp_pkg::APB_DW-1:0]  prdata,
    output wlp_pkg::t_cfg               o_cfg
);
    import wlp_pkg::*;

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_LABEL_WIDTH:    n_cfg.label_width    = pwdata[CFG_W-1:0];
                REG_LABEL_SPACING:  n_cfg.label_spacing  = pwdata[CFG_W-1:0];
                REG_OUTLINE_ENABLE: n_cfg.outline_enable = pwdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.label_width    <= RST_LABEL_WIDTH;
            r_cfg.label_spacing  <= RST_LABEL_SPACING;
            r_cfg.outline_enable <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_LABEL_WIDTH:    prdata = APB_DW'(r_cfg.label_width);
            REG_LABEL_SPACING:  prdata = APB_DW'(r_cfg.label_spacing);
            REG_OUTLINE_ENABLE: prdata = APB_DW'(r_cfg.outline_enable);
            default:            prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/wlp_ctrl.sv =====
module wlp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  wlp_pkg::t_sts i_sts,
    output wlp_pkg::t_cmd o_cmd
);
    import wlp_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQX  = 3'd1;
    localparam logic [2:0] ST_SQY  = 3'd2;
    localparam logic [2:0] ST_SUM  = 3'd3;
    localparam logic [2:0] ST_ROOT = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    localparam int CNT_W = $clog2(SQ_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SQ_W - 1);

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    if (!i_sts.new_way) begin
                        n_state = ST_SQX;
                    end
                end
            end
            ST_SQX: begin
                o_cmd.sq_x = 1'b1;
                n_state    = ST_SQY;
            end
            ST_SQY: begin
                o_cmd.sq_y = 1'b1;
                n_state    = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_cnt     = '0;
                n_state   = ST_ROOT;
            end
            ST_ROOT: begin
                o_cmd.root_step = 1'b1;
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // A new result may only land once the output register is free.
                if (!i_sts.emit || !r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.finish && i_sts.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== sv/wlp_dpath.sv =====
module wlp_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wlp_pkg::t_in_item  i_in,
    input  wlp_pkg::t_cfg      i_cfg,
    input  wlp_pkg::t_cmd      i_cmd,
    output wlp_pkg::t_sts      o_sts,
    output wlp_pkg::t_out_item o_out
);
    import wlp_pkg::*;

    logic signed [COORD_WIDTH-1:0] r_prev_x;
    logic signed [COORD_WIDTH-1:0] r_prev_y;
    logic signed [COORD_WIDTH-1:0] r_seg_x;
    logic signed [COORD_WIDTH-1:0] r_seg_y;
    logic                          r_have_prev;
    logic signed [SKIP_W-1:0]      r_skip;
    logic signed [SKIP_W-1:0]      n_skip;
    logic [DIFF_W-1:0]             r_dx;
    logic [DIFF_W-1:0]             r_dy;
    logic [PROD_W-1:0]             r_sq_x;
    logic [PROD_W-1:0]             r_sq_y;
    logic [RAD_W-1:0]              r_rad;
    logic [REM_W-1:0]              r_rem;
    logic [SQ_W-1:0]               r_root;
    t_out_item                     r_out;

    logic signed [DIFF_W:0] diff_x;
    logic signed [DIFF_W:0] diff_y;
    logic [DIFF_W:0]        abs_x;
    logic [DIFF_W:0]        abs_y;
    logic [DIFF_W-1:0]      mul_op;
    logic [PROD_W-1:0]      mul_prod;
    logic [REM_W-1:0]       rem_sh;
    logic [REM_W-1:0]       trial;
    logic                   skip_pos;
    logic [CMP_W-1:0]       thresh;
    logic                   long_enough;
    logic signed [SUB_W-1:0] sub_val;
    logic [SUB_W-1:0]       sub_mag;
    logic                   prev_left;

    // Differences against the stored vertex, taken as the item is accepted.
    assign diff_x = $signed({i_in.vertex_x[COORD_WIDTH-1], i_in.vertex_x})
                  - $signed({r_prev_x[COORD_WIDTH-1], r_prev_x});
    assign diff_y = $signed({i_in.vertex_y[COORD_WIDTH-1], i_in.vertex_y})
                  - $signed({r_prev_y[COORD_WIDTH-1], r_prev_y});
    assign abs_x  = diff_x[DIFF_W] ? (DIFF_W+1)'(0) - diff_x : diff_x;
    assign abs_y  = diff_y[DIFF_W] ? (DIFF_W+1)'(0) - diff_y : diff_y;

    // One multiplier serves both squares.
    assign mul_op   = i_cmd.sq_y ? r_dy : r_dx;
    assign mul_prod = mul_op * mul_op;

    // Restoring square root, one result bit per step.
    assign rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1:RAD_W-2]};
    assign trial  = {1'b0, r_root, 2'b01};

    assign skip_pos    = !r_skip[SKIP_W-1] && (r_skip != '0);
    assign thresh      = CMP_W'(i_cfg.label_width) << FRAC_BITS;
    assign long_enough = CMP_W'(r_root) > thresh;
    assign prev_left   = r_seg_x <= r_prev_x;

    assign o_sts.new_way = i_in.way_start || !r_have_prev;
    assign o_sts.emit    = !skip_pos && long_enough;

    always_comb begin
        sub_val = ($signed({{(SUB_W-SKIP_W){r_skip[SKIP_W-1]}}, r_skip}) <<< FRAC_BITS)
                - $signed(SUB_W'(r_root));
        sub_mag = SUB_W'(0) - sub_val;
        n_skip  = r_skip;
        if (skip_pos) begin
            // Truncate toward zero in whole pixels.
            if (!sub_val[SUB_W-1]) begin
                n_skip = SKIP_W'(sub_val >>> FRAC_BITS);
            end else begin
                n_skip = SKIP_W'(SUB_W'(0) - (sub_mag >> FRAC_BITS));
            end
        end else if (long_enough) begin
            n_skip = SKIP_W'(i_cfg.label_spacing);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_have_prev <= 1'b0;
            r_skip      <= '0;
        end else begin
            if (i_cmd.load) begin
                r_prev_x    <= i_in.vertex_x;
                r_prev_y    <= i_in.vertex_y;
                r_have_prev <= 1'b1;
                if (o_sts.new_way) begin
                    r_skip <= '0;
                end
            end
            if (i_cmd.finish) begin
                r_skip <= n_skip;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_seg_x <= r_prev_x;
            r_seg_y <= r_prev_y;
            r_dx    <= abs_x[DIFF_W-1:0];
            r_dy    <= abs_y[DIFF_W-1:0];
        end
        if (i_cmd.sq_x) begin
            r_sq_x <= mul_prod;
        end
        if (i_cmd.sq_y) begin
            r_sq_y <= mul_prod;
        end
        if (i_cmd.sum) begin
            r_rad  <= RAD_W'(r_sq_x) + RAD_W'(r_sq_y);
            r_rem  <= '0;
            r_root <= '0;
        end
        if (i_cmd.root_step) begin
            r_rad <= r_rad << 2;
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[SQ_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[SQ_W-2:0], 1'b0};
            end
        end
        if (i_cmd.finish && o_sts.emit) begin
            r_out.left_x       <= prev_left ? r_seg_x : r_prev_x;
            r_out.left_y       <= prev_left ? r_seg_y : r_prev_y;
            r_out.right_x      <= prev_left ? r_prev_x : r_seg_x;
            r_out.right_y      <= prev_left ? r_prev_y : r_seg_y;
            r_out.with_outline <= i_cfg.outline_enable;
        end
    end

    assign o_out = r_out;

endmodule
